// ===== sv/nps_pkg.sv =====
package nps_pkg;

	// the table is spread over a row of cells, point i lives in cell i mod NCELL
	localparam int CELL_BITS = 2;
	localparam int NCELL = 1 << CELL_BITS;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_COORD_BITS = 16;

	localparam int REQ_W = 2;
	localparam int ST_W = 2;
	localparam int IDX_OUT_W = 10;

	localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// control bits of a search token travelling down the cell row
	typedef struct packed {
		logic vld;
		logic last;
		logic found;
	} nps_ctl_t;

endpackage

// ===== sv/nps_req_if.sv =====
interface nps_req_if import nps_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [REQ_W-1:0]      req_type;
	logic [COORD_BITS-1:0] point_col;
	logic [COORD_BITS-1:0] point_row;

	modport source (output valid, output req_type, output point_col, output point_row,
		input ready);
	modport sink (input valid, input req_type, input point_col, input point_row,
		output ready);
endinterface

// ===== sv/nps_res_if.sv =====
interface nps_res_if import nps_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic [IDX_OUT_W-1:0]    nearest_index;
	logic [COORD_BITS-1:0]   nearest_col;
	logic [COORD_BITS-1:0]   nearest_row;
	logic [2*COORD_BITS:0]   distance_squared;

	modport source (output valid, output status, output nearest_index, output nearest_col,
		output nearest_row, output distance_squared, input ready);
	modport sink (input valid, input status, input nearest_index, input nearest_col,
		input nearest_row, input distance_squared, output ready);
endinterface

// ===== sv/nps_cell.sv =====
module nps_cell import nps_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int SEG = 1,
	parameter int SEG_W = 1,
	parameter int CW = SEG_W + CELL_BITS + 1,
	parameter int CELL_ID = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [CELL_BITS-1:0]        wr_cell,
	input  logic [SEG_W-1:0]            wr_addr,
	input  logic [COORD_BITS-1:0]       wr_col,
	input  logic [COORD_BITS-1:0]       wr_row,
	input  logic [CW-1:0]               count,
	input  nps_ctl_t                    ctl_in,
	input  logic [SEG_W-1:0]            addr_in,
	input  logic [COORD_BITS-1:0]       qcol_in,
	input  logic [COORD_BITS-1:0]       qrow_in,
	input  logic [CW-2:0]               bidx_in,
	input  logic [COORD_BITS-1:0]       bcol_in,
	input  logic [COORD_BITS-1:0]       brow_in,
	input  logic [2*COORD_BITS:0]       bdist_in,
	output nps_ctl_t                    ctl_out,
	output logic [SEG_W-1:0]            addr_out,
	output logic [COORD_BITS-1:0]       qcol_out,
	output logic [COORD_BITS-1:0]       qrow_out,
	output logic [CW-2:0]               bidx_out,
	output logic [COORD_BITS-1:0]       bcol_out,
	output logic [COORD_BITS-1:0]       brow_out,
	output logic [2*COORD_BITS:0]       bdist_out
);
	localparam int IW = CW - 1;
	localparam int DW = 2 * COORD_BITS + 1;
	localparam int SW = 2 * COORD_BITS;

	logic [SW-1:0] mem [SEG];

	nps_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic [SEG_W-1:0]      addr_s1, addr_s2, addr_s3, addr_s4;
	logic [COORD_BITS-1:0] qcol_s1, qcol_s2, qcol_s3, qcol_s4;
	logic [COORD_BITS-1:0] qrow_s1, qrow_s2, qrow_s3, qrow_s4;
	logic [IW-1:0]         bidx_s1, bidx_s2, bidx_s3, bidx_s4;
	logic [COORD_BITS-1:0] bcol_s1, bcol_s2, bcol_s3, bcol_s4;
	logic [COORD_BITS-1:0] brow_s1, brow_s2, brow_s3, brow_s4;
	logic [DW-1:0]         bdist_s1, bdist_s2, bdist_s3, bdist_s4;

	logic [SW-1:0]         pt_s1;
	logic [COORD_BITS-1:0] pcol_s2, pcol_s3;
	logic [COORD_BITS-1:0] prow_s2, prow_s3;
	logic [COORD_BITS-1:0] dc_s2, dr_s2;
	logic [SW-1:0]         sqc_s3, sqr_s3;
	logic [IW-1:0]         idx_s2, idx_s3;
	logic                  hit_s2, hit_s3;

	logic [COORD_BITS-1:0] pcol, prow;
	logic [IW-1:0]         idx;
	logic [DW-1:0]         cand_dist;
	logic                  take;

	assign pcol = pt_s1[SW-1:COORD_BITS];
	assign prow = pt_s1[COORD_BITS-1:0];
	assign idx  = {addr_s1, CELL_BITS'(CELL_ID)};
	assign cand_dist = DW'(sqc_s3) + DW'(sqr_s3);
	// strict compare keeps the earlier point on a tie
	assign take = hit_s3 && (!ctl_s3.found || cand_dist < bdist_s3);

	// point table slice, registered read
	always_ff @(posedge clk) begin
		if (wr_en && wr_cell == CELL_BITS'(CELL_ID)) begin
			mem[wr_addr] <= {wr_col, wr_row};
		end
		pt_s1 <= mem[addr_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{vld: ctl_s3.vld, last: ctl_s3.last, found: ctl_s3.found | take};
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= addr_in;
		qcol_s1  <= qcol_in;
		qrow_s1  <= qrow_in;
		bidx_s1  <= bidx_in;
		bcol_s1  <= bcol_in;
		brow_s1  <= brow_in;
		bdist_s1 <= bdist_in;

		addr_s2  <= addr_s1;
		qcol_s2  <= qcol_s1;
		qrow_s2  <= qrow_s1;
		bidx_s2  <= bidx_s1;
		bcol_s2  <= bcol_s1;
		brow_s2  <= brow_s1;
		bdist_s2 <= bdist_s1;
		pcol_s2  <= pcol;
		prow_s2  <= prow;
		dc_s2    <= (qcol_s1 >= pcol) ? (qcol_s1 - pcol) : (pcol - qcol_s1);
		dr_s2    <= (qrow_s1 >= prow) ? (qrow_s1 - prow) : (prow - qrow_s1);
		idx_s2   <= idx;
		// entries at or past the fill count hold no valid point of the current table
		hit_s2   <= {1'b0, idx} < count;

		addr_s3  <= addr_s2;
		qcol_s3  <= qcol_s2;
		qrow_s3  <= qrow_s2;
		bidx_s3  <= bidx_s2;
		bcol_s3  <= bcol_s2;
		brow_s3  <= brow_s2;
		bdist_s3 <= bdist_s2;
		pcol_s3  <= pcol_s2;
		prow_s3  <= prow_s2;
		sqc_s3   <= SW'(dc_s2) * SW'(dc_s2);
		sqr_s3   <= SW'(dr_s2) * SW'(dr_s2);
		idx_s3   <= idx_s2;
		hit_s3   <= hit_s2;

		addr_s4  <= addr_s3;
		qcol_s4  <= qcol_s3;
		qrow_s4  <= qrow_s3;
		bidx_s4  <= take ? idx_s3    : bidx_s3;
		bcol_s4  <= take ? pcol_s3   : bcol_s3;
		brow_s4  <= take ? prow_s3   : brow_s3;
		bdist_s4 <= take ? cand_dist : bdist_s3;
	end

	assign ctl_out   = ctl_s4;
	assign addr_out  = addr_s4;
	assign qcol_out  = qcol_s4;
	assign qrow_out  = qrow_s4;
	assign bidx_out  = bidx_s4;
	assign bcol_out  = bcol_s4;
	assign brow_out  = brow_s4;
	assign bdist_out = bdist_s4;

endmodule

// ===== sv/nearest_point_search.sv =====
// channel | side   | word                                                    | handshake
// req     | sink   | req_type, point_col, point_row                          | valid/ready
// res     | source | status, nearest_index, nearest_col, nearest_row,        | valid/ready
//         |        | distance_squared                                        |
//
// start, append and unused codes: result word is registered, valid in the cycle after the request is taken
// query: one search token per cycle into a row of four cells
// of four stages each, each cell holding every fourth point of the table
// reset clears the fill count; table contents stay undefined, no clearing pass
// req.ready is low while a query scans and while an untaken result word waits
module nearest_point_search import nps_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	nps_req_if.sink   req,
	nps_res_if.source res
);
	localparam int SEG = (MAX_POINTS + NCELL - 1) / NCELL;
	localparam int SEG_W = (SEG > 1) ? $clog2(SEG) : 1;
	localparam int IW = SEG_W + CELL_BITS;
	localparam int CW = IW + 1;
	localparam int DW = 2 * COORD_BITS + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t state_q;

	logic [CW-1:0]         count_q;
	logic [SEG_W-1:0]      issue_q, last_q;
	logic [COORD_BITS-1:0] qcol_q, qrow_q;

	logic                  acc_found_q;
	logic [IW-1:0]         acc_idx_q;
	logic [COORD_BITS-1:0] acc_col_q, acc_row_q;
	logic [DW-1:0]         acc_dist_q;

	logic                  res_vld_q;
	logic [ST_W-1:0]       res_status_q;
	logic [IDX_OUT_W-1:0]  res_idx_q;
	logic [COORD_BITS-1:0] res_col_q, res_row_q;
	logic [DW-1:0]         res_dist_q;

	nps_ctl_t              ctl_c   [NCELL+1];
	logic [SEG_W-1:0]      addr_c  [NCELL+1];
	logic [COORD_BITS-1:0] qcol_c  [NCELL+1];
	logic [COORD_BITS-1:0] qrow_c  [NCELL+1];
	logic [IW-1:0]         bidx_c  [NCELL+1];
	logic [COORD_BITS-1:0] bcol_c  [NCELL+1];
	logic [COORD_BITS-1:0] brow_c  [NCELL+1];
	logic [DW-1:0]         bdist_c [NCELL+1];

	logic                  accept;
	logic                  full;
	logic                  wr_en;
	logic [CELL_BITS-1:0]  wr_cell;
	logic [SEG_W-1:0]      wr_addr;
	logic [CW:0]           nseg_sum, nseg_m1;
	nps_ctl_t              tail;
	logic                  t_take;
	logic [IW-1:0]         fin_idx;
	logic [COORD_BITS-1:0] fin_col, fin_row;
	logic [DW-1:0]         fin_dist;

	assign req.ready = (state_q == S_IDLE) && (!res_vld_q || res.ready);
	assign accept    = req.valid && req.ready;

	assign full    = count_q >= CW'(MAX_POINTS);
	assign wr_en   = accept && (req.req_type == REQ_START
		|| (req.req_type == REQ_APPEND && !full));
	assign wr_cell = (req.req_type == REQ_START) ? '0 : count_q[CELL_BITS-1:0];
	assign wr_addr = (req.req_type == REQ_START) ? '0 : count_q[CELL_BITS +: SEG_W];

	// number of table rows to scan, less one
	assign nseg_sum = {1'b0, count_q} + (CW+1)'(NCELL - 1);
	assign nseg_m1  = (nseg_sum >> CELL_BITS) - (CW+1)'(1);

	assign ctl_c[0]   = '{vld: state_q == S_SCAN, last: issue_q == last_q, found: 1'b0};
	assign addr_c[0]  = issue_q;
	assign qcol_c[0]  = qcol_q;
	assign qrow_c[0]  = qrow_q;
	assign bidx_c[0]  = '0;
	assign bcol_c[0]  = '0;
	assign brow_c[0]  = '0;
	assign bdist_c[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		nps_cell #(
			.COORD_BITS (COORD_BITS),
			.SEG        (SEG),
			.SEG_W      (SEG_W),
			.CW         (CW),
			.CELL_ID    (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_en),
			.wr_cell   (wr_cell),
			.wr_addr   (wr_addr),
			.wr_col    (req.point_col),
			.wr_row    (req.point_row),
			.count     (count_q),
			.ctl_in    (ctl_c[k]),
			.addr_in   (addr_c[k]),
			.qcol_in   (qcol_c[k]),
			.qrow_in   (qrow_c[k]),
			.bidx_in   (bidx_c[k]),
			.bcol_in   (bcol_c[k]),
			.brow_in   (brow_c[k]),
			.bdist_in  (bdist_c[k]),
			.ctl_out   (ctl_c[k+1]),
			.addr_out  (addr_c[k+1]),
			.qcol_out  (qcol_c[k+1]),
			.qrow_out  (qrow_c[k+1]),
			.bidx_out  (bidx_c[k+1]),
			.bcol_out  (bcol_c[k+1]),
			.brow_out  (brow_c[k+1]),
			.bdist_out (bdist_c[k+1])
		);
	end

	// tokens leave the row in table order, so a strict compare keeps the first minimum
	assign tail     = ctl_c[NCELL];
	assign t_take   = tail.found && (!acc_found_q || bdist_c[NCELL] < acc_dist_q);
	assign fin_idx  = t_take ? bidx_c[NCELL]  : acc_idx_q;
	assign fin_col  = t_take ? bcol_c[NCELL]  : acc_col_q;
	assign fin_row  = t_take ? brow_c[NCELL]  : acc_row_q;
	assign fin_dist = t_take ? bdist_c[NCELL] : acc_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_vld_q   <= 1'b0;
			count_q     <= '0;
			issue_q     <= '0;
			acc_found_q <= 1'b0;
		end else begin
			if (res_vld_q && res.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_idx_q    <= '0;
						res_col_q    <= '0;
						res_row_q    <= '0;
						res_dist_q   <= '0;
						res_vld_q    <= 1'b1;
						case (req.req_type)
							REQ_START: begin
								count_q <= CW'(1);
							end
							REQ_APPEND: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							REQ_QUERY: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									res_vld_q   <= 1'b0;
									state_q     <= S_SCAN;
									issue_q     <= '0;
									last_q      <= nseg_m1[SEG_W-1:0];
									qcol_q      <= req.point_col;
									qrow_q      <= req.point_row;
									acc_found_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					issue_q <= issue_q + SEG_W'(1);
					if (issue_q == last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (tail.vld) begin
				acc_found_q <= acc_found_q | t_take;
				acc_idx_q   <= fin_idx;
				acc_col_q   <= fin_col;
				acc_row_q   <= fin_row;
				acc_dist_q  <= fin_dist;
				if (tail.last) begin
					res_status_q <= ST_OK;
					res_idx_q    <= IDX_OUT_W'(fin_idx);
					res_col_q    <= fin_col;
					res_row_q    <= fin_row;
					res_dist_q   <= fin_dist;
					res_vld_q    <= 1'b1;
					state_q      <= S_IDLE;
				end
			end
		end
	end

	assign res.valid            = res_vld_q;
	assign res.status           = res_status_q;
	assign res.nearest_index    = res_idx_q;
	assign res.nearest_col      = res_col_q;
	assign res.nearest_row      = res_row_q;
	assign res.distance_squared = res_dist_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("fill count beyond table size");

	a_tail_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("search token left the cell row outside a query");

	a_last_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld && tail.last |-> state_q == S_DRAIN)
		else $error("final token arrived before issue finished");

	a_last_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld && tail.last |-> (acc_found_q || tail.found))
		else $error("query finished with no stored point matched");

endmodule
